@@ rtl/core/rsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, operation and status codes, state and payload types for the
// reference counting slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int OP_W     = 3;
   localparam int HANDLE_W = 6;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 16;
   localparam int LIVE_W   = 7;
   localparam int THR_W    = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_W-1:0] OP_BORROW    = 3'd1;
   localparam logic [OP_W-1:0] OP_DONE      = 3'd2;
   localparam logic [OP_W-1:0] OP_SWEEP     = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_OBJECT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED    = 3'd4;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd25;
   localparam logic [THR_W-1:0] ALLOC_MAX       = 8'd255;

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_RMW    = 7'b0000100,
      S_SWEEP  = 7'b0001000,
      S_SEARCH = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_HOLD   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] result_handle;
      logic [VALUE_W-1:0]  ref_value;
      logic [LIVE_W-1:0]   live_objects;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/rsa_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_req_if
// Request channel: operation code and slot handle with valid/ready.
// ----------------------------------------------------------------------------
interface rsa_req_if;
   logic                          valid;
   logic                          ready;
   logic [rsa_pkg::OP_W-1:0]      operation;
   logic [rsa_pkg::HANDLE_W-1:0]  handle;

   modport source (output valid, operation, handle, input ready);
   modport sink   (input valid, operation, handle, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rsa_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_rsp_if
// Response channel: status, handle, count and live slot total with valid/ready.
// ----------------------------------------------------------------------------
interface rsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rsa_pkg::STATUS_W-1:0]  status;
   logic [rsa_pkg::HANDLE_W-1:0]  result_handle;
   logic [rsa_pkg::VALUE_W-1:0]   ref_value;
   logic [rsa_pkg::LIVE_W-1:0]    live_objects;

   modport source (output valid, status, result_handle, ref_value, live_objects,
                   input ready);
   modport sink   (input valid, status, result_handle, ref_value, live_objects,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/core/rsa_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_csr_if
// Register write channel for the sweep threshold with valid/ready.
// ----------------------------------------------------------------------------
interface rsa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [rsa_pkg::THR_W-1:0]  sweep_threshold;

   modport source (output valid, sweep_threshold, input ready);
   modport sink   (input valid, sweep_threshold, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rsa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/refcount_slot_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// refcount_slot_allocator
// Slot table with reference counts, lowest-free allocation and deferred sweep.
// ----------------------------------------------------------------------------
// Each slot's valid mark and count live together in one RAM with a registered
// read, and every operation is a walk or a read-modify-write of that RAM, one
// item at a time. Borrow and done read the slot, then modify and write it back;
// unused codes read it and return OK without a write. Sweep and clear all walk
// the table one slot per cycle. Alloc walks from slot 0 up to the lowest free
// slot, or through every slot when the table is full; when the allocation
// counter has reached the threshold a sweep runs first. After reset a clearing
// pass over every slot runs before the first request is taken; register writes
// are taken at any time. A finished result waits in a holding register while
// the response output is stalled, so the next request is only held off by a
// stalled output once both are full.
// ----------------------------------------------------------------------------
module refcount_slot_allocator #(
   parameter int SLOTS      = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rsa_req_if.sink    req_if,
   rsa_rsp_if.source  rsp_if,
   rsa_csr_if.sink    csr_if
);

   localparam int AW = $clog2(SLOTS);
   localparam int SW = $clog2(SLOTS + 1);
   localparam int DW = COUNT_BITS + 1;

   localparam logic [AW-1:0]         LAST_SLOT = AW'(SLOTS - 1);
   localparam logic [SW-1:0]         SCAN_END  = SW'(SLOTS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   rsa_pkg::state_type               state_ff, state_in;
   logic [rsa_pkg::OP_W-1:0]         op_ff, op_in;
   logic [rsa_pkg::HANDLE_W-1:0]     handle_ff, handle_in;
   logic                             auto_ff, auto_in;
   logic [SW-1:0]                    scan_ff, scan_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    tag_ff, tag_in;
   logic [SW-1:0]                    live_ff, live_in;
   logic [rsa_pkg::THR_W-1:0]        allocs_ff, allocs_in;
   logic [rsa_pkg::THR_W-1:0]        thr_ff, thr_in;
   rsa_pkg::rsp_type                 hold_ff, hold_in;
   rsa_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [DW-1:0]                    wr_data;
   logic [AW-1:0]                    rd_addr;
   logic [DW-1:0]                    rd_data;

   logic                             rd_valid;
   logic [COUNT_BITS-1:0]            rd_count;
   logic                             req_fire;
   logic                             rsp_free;
   logic                             known;
   logic                             scan_more;
   logic                             fin;
   rsa_pkg::rsp_type                 res;

   rsa_ram #(
      .WIDTH (DW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_valid  = rd_data[COUNT_BITS];
   assign rd_count  = rd_data[COUNT_BITS-1:0];
   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign known     = (32'(handle_ff) < SLOTS) && rd_valid;
   assign scan_more = scan_ff < SCAN_END;

   assign req_if.ready         = (state_ff == rsa_pkg::S_IDLE);
   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_ff.status;
   assign rsp_if.result_handle = rsp_ff.result_handle;
   assign rsp_if.ref_value     = rsp_ff.ref_value;
   assign rsp_if.live_objects  = rsp_ff.live_objects;

   assign thr_in = (csr_if.valid && csr_if.ready) ? csr_if.sweep_threshold : thr_ff;

   always_comb begin
      logic [COUNT_BITS-1:0] val;
      val          = '0;
      state_in     = state_ff;
      op_in        = op_ff;
      handle_in    = handle_ff;
      auto_in      = auto_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      tag_in       = tag_ff;
      live_in      = live_ff;
      allocs_in    = allocs_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      wr_en        = 1'b0;
      wr_addr      = tag_ff;
      wr_data      = '0;
      rd_addr      = scan_ff[AW-1:0];
      fin          = 1'b0;
      res          = '0;
      res.status        = rsa_pkg::ST_OK;
      res.result_handle = handle_ff;

      // walk: issue one read per cycle, data comes back tagged on the next cycle
      if ((state_ff == rsa_pkg::S_SWEEP || state_ff == rsa_pkg::S_SEARCH) && scan_more) begin
         scan_in = scan_ff + SW'(1);
         pend_in = 1'b1;
         tag_in  = scan_ff[AW-1:0];
      end

      case (state_ff)
         rsa_pkg::S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[AW-1:0];
            scan_in = scan_ff + SW'(1);
            if (scan_ff[AW-1:0] == LAST_SLOT) begin
               state_in = rsa_pkg::S_IDLE;
            end
         end
         rsa_pkg::S_IDLE: begin
            rd_addr = AW'(req_if.handle);
            if (req_fire) begin
               op_in     = req_if.operation;
               handle_in = req_if.handle;
               scan_in   = '0;
               auto_in   = 1'b0;
               case (req_if.operation)
                  rsa_pkg::OP_ALLOC: begin
                     if (allocs_ff >= thr_ff) begin
                        state_in  = rsa_pkg::S_SWEEP;
                        auto_in   = 1'b1;
                        allocs_in = '0;
                     end else begin
                        state_in = rsa_pkg::S_SEARCH;
                     end
                  end
                  rsa_pkg::OP_SWEEP: begin
                     state_in = rsa_pkg::S_SWEEP;
                  end
                  rsa_pkg::OP_CLEAR_ALL: begin
                     state_in = rsa_pkg::S_CLEAR;
                     live_in  = '0;
                  end
                  default: begin
                     state_in = rsa_pkg::S_RMW;
                  end
               endcase
            end
         end
         rsa_pkg::S_RMW: begin
            fin     = 1'b1;
            wr_addr = AW'(handle_ff);
            case (op_ff)
               rsa_pkg::OP_BORROW: begin
                  if (!known) begin
                     res.status = rsa_pkg::ST_NO_OBJECT;
                  end else if (rd_count == COUNT_MAX) begin
                     res.status = rsa_pkg::ST_SATURATED;
                     val        = rd_count;
                  end else begin
                     val     = rd_count + COUNT_ONE;
                     wr_en   = 1'b1;
                     wr_data = {1'b1, val};
                  end
               end
               rsa_pkg::OP_DONE: begin
                  if (!known) begin
                     res.status = rsa_pkg::ST_NO_OBJECT;
                  end else if (rd_count == '0) begin
                     res.status = rsa_pkg::ST_ALREADY_ZERO;
                  end else begin
                     val     = rd_count - COUNT_ONE;
                     wr_en   = 1'b1;
                     wr_data = {1'b1, val};
                  end
               end
               default: begin
               end
            endcase
         end
         rsa_pkg::S_SWEEP: begin
            if (pend_ff && rd_valid && rd_count == '0) begin
               wr_en   = 1'b1;
               live_in = live_ff - SW'(1);
            end
            if (pend_ff && tag_ff == LAST_SLOT) begin
               if (auto_ff) begin
                  // threshold sweep done, now look for the free slot
                  state_in = rsa_pkg::S_SEARCH;
                  scan_in  = '0;
                  pend_in  = 1'b0;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         rsa_pkg::S_SEARCH: begin
            if (pend_ff && !rd_valid) begin
               wr_en             = 1'b1;
               wr_data           = {1'b1, COUNT_ONE};
               live_in           = live_ff + SW'(1);
               allocs_in         = (allocs_ff == rsa_pkg::ALLOC_MAX) ?
                                   allocs_ff : allocs_ff + 8'd1;
               val               = COUNT_ONE;
               res.result_handle = rsa_pkg::HANDLE_W'(tag_ff);
               fin               = 1'b1;
            end else if (pend_ff && tag_ff == LAST_SLOT) begin
               res.status        = rsa_pkg::ST_TABLE_FULL;
               res.result_handle = '0;
               fin               = 1'b1;
            end
         end
         rsa_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[AW-1:0];
            scan_in = scan_ff + SW'(1);
            if (scan_ff[AW-1:0] == LAST_SLOT) begin
               fin = 1'b1;
            end
         end
         rsa_pkg::S_HOLD: begin
            if (rsp_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = rsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rsa_pkg::S_IDLE;
         end
      endcase

      res.ref_value    = rsa_pkg::VALUE_W'(val);
      res.live_objects = rsa_pkg::LIVE_W'(live_in);

      // result goes straight out when the output is free, else parks
      if (fin) begin
         if (rsp_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = rsa_pkg::S_IDLE;
         end else begin
            hold_in  = res;
            state_in = rsa_pkg::S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::S_INIT;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         live_ff      <= '0;
         allocs_ff    <= '0;
         thr_ff       <= rsa_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         live_ff      <= live_in;
         allocs_ff    <= allocs_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      handle_ff <= handle_in;
      auto_ff   <= auto_in;
      tag_ff    <= tag_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= SW'(SLOTS))
      else $error("live slot total exceeds table size");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsa_pkg::S_IDLE || state_ff == rsa_pkg::S_HOLD) |-> !wr_en)
      else $error("table written while no operation is in progress");

   a_rmw_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_if.operation == rsa_pkg::OP_BORROW ||
                   req_if.operation == rsa_pkg::OP_DONE)
      |=> state_ff == rsa_pkg::S_RMW)
      else $error("borrow or done did not enter read-modify-write");
`endif

endmodule
`default_nettype wire
